/* hdl/pbm_pkg.sv */
// Shared types, character constants and the character classifier of the boundary marker.
package pbm_pkg;

	// Widest codepoint the classifier looks at
	localparam int CP_MAX_BITS = 21;

	localparam logic [CP_MAX_BITS-1:0] CP_APOS  = 21'h27;
	localparam logic [CP_MAX_BITS-1:0] CP_SPACE = 21'h20;
	localparam logic [CP_MAX_BITS-1:0] CP_LOW_S = 21'h73;
	localparam logic [CP_MAX_BITS-1:0] CP_LOW_T = 21'h74;
	localparam logic [CP_MAX_BITS-1:0] CP_LOW_M = 21'h6D;
	localparam logic [CP_MAX_BITS-1:0] CP_LOW_D = 21'h64;
	localparam logic [CP_MAX_BITS-1:0] CP_LOW_R = 21'h72;
	localparam logic [CP_MAX_BITS-1:0] CP_LOW_V = 21'h76;
	localparam logic [CP_MAX_BITS-1:0] CP_LOW_E = 21'h65;
	localparam logic [CP_MAX_BITS-1:0] CP_LOW_L = 21'h6C;

	typedef enum logic [1:0] {
		CLS_LET,
		CLS_DIG,
		CLS_SPC,
		CLS_OTH
	} cls_t;

	// Classified work for one codepoint, handed from the front to the back
	typedef struct packed {
		cls_t c_cls;
		cls_t c1_cls;
		logic is_apos;
		logic is_space;
		logic short_ctr;
		logic long_ctr;
		logic last;
	} job_t;

	function automatic cls_t cp_class(input logic [CP_MAX_BITS-1:0] c);
		cls_t r;
		if (c inside {[21'h41:21'h5A], [21'h61:21'h7A], [21'hC0:21'hD6], [21'hD8:21'hF6],
				[21'hF8:21'h131], [21'h134:21'h143]}) begin
			r = CLS_LET;
		end else if (c inside {[21'h30:21'h39], 21'hB2, 21'hB3, 21'hB9}) begin
			r = CLS_DIG;
		end else if (c inside {[21'h08:21'h0D], [21'h1C:21'h20], 21'h85, 21'hA0}) begin
			r = CLS_SPC;
		end else begin
			r = CLS_OTH;
		end
		return r;
	endfunction

endpackage

/* hdl/pbm_fifo.sv */
// Two-entry queue used between front and back and in front of the result ports.
module pbm_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_wr) wptr_q <= ~wptr_q;
			if (do_rd) rptr_q <= ~rptr_q;
			if (do_wr && !do_rd) count_q <= count_q + 2'd1;
			else if (do_rd && !do_wr) count_q <= count_q - 2'd1;
		end
	end

	// Store the incoming entry
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wr_data;
	end

endmodule

/* hdl/pbm_front.sv */
// Front end: holds the two-codepoint lookahead window, classifies and issues jobs.
module pbm_front #(
	parameter int CODEPOINT_BITS = 11
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [CODEPOINT_BITS-1:0] codepoint,
	input  logic                      end_of_text,
	output logic                      job_push,
	input  logic                      job_full,
	output logic [CODEPOINT_BITS-1:0] job_char,
	output pbm_pkg::job_t             job
);

	logic [CODEPOINT_BITS-1:0] hold_q [3];
	logic [1:0]                n_q;
	logic                      flush_q;
	logic                      accept;
	logic [CODEPOINT_BITS-1:0] c1_raw;
	logic [CODEPOINT_BITS-1:0] c2_raw;
	logic                      c1_ok;
	logic                      c2_ok;
	logic [pbm_pkg::CP_MAX_BITS-1:0] cw;
	logic [pbm_pkg::CP_MAX_BITS-1:0] c1w;
	logic [pbm_pkg::CP_MAX_BITS-1:0] c2w;

	assign full   = flush_q | ((n_q == 2'd2) & job_full);
	assign accept = push & ~full;

	// Pick the window for the job being issued
	always_comb begin
		if (flush_q) begin
			c1_raw = hold_q[1];
			c2_raw = hold_q[2];
			c1_ok  = (n_q >= 2'd2);
			c2_ok  = (n_q == 2'd3);
		end else begin
			c1_raw = hold_q[1];
			c2_raw = codepoint;
			c1_ok  = 1'b1;
			c2_ok  = 1'b1;
		end
	end

	assign job_push = flush_q ? ~job_full : (accept & ~end_of_text & (n_q == 2'd2));
	assign job_char = hold_q[0];

	assign cw  = pbm_pkg::CP_MAX_BITS'(hold_q[0]);
	assign c1w = pbm_pkg::CP_MAX_BITS'(c1_raw);
	assign c2w = pbm_pkg::CP_MAX_BITS'(c2_raw);

	// Classify the codepoint and its lookahead; a missing lookahead is other
	always_comb begin
		job.c_cls     = pbm_pkg::cp_class(cw);
		job.c1_cls    = c1_ok ? pbm_pkg::cp_class(c1w) : pbm_pkg::CLS_OTH;
		job.is_apos   = (cw == pbm_pkg::CP_APOS);
		job.is_space  = (cw == pbm_pkg::CP_SPACE);
		job.short_ctr = c1_ok && ((c1w == pbm_pkg::CP_LOW_S) || (c1w == pbm_pkg::CP_LOW_T) ||
			(c1w == pbm_pkg::CP_LOW_M) || (c1w == pbm_pkg::CP_LOW_D));
		job.long_ctr  = c1_ok && c2_ok &&
			(((c1w == pbm_pkg::CP_LOW_R) && (c2w == pbm_pkg::CP_LOW_E)) ||
			 ((c1w == pbm_pkg::CP_LOW_V) && (c2w == pbm_pkg::CP_LOW_E)) ||
			 ((c1w == pbm_pkg::CP_LOW_L) && (c2w == pbm_pkg::CP_LOW_L)));
		job.last      = flush_q && (n_q == 2'd1);
	end

	// Track window fill and the end-of-text drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= 2'd0;
			flush_q <= 1'b0;
		end else if (flush_q) begin
			if (!job_full) begin
				n_q <= n_q - 2'd1;
				if (n_q == 2'd1) flush_q <= 1'b0;
			end
		end else if (accept) begin
			if (end_of_text) begin
				n_q     <= n_q + 2'd1;
				flush_q <= 1'b1;
			end else if (n_q != 2'd2) begin
				n_q <= n_q + 2'd1;
			end
		end
	end

	// Shift or fill the window
	always_ff @(posedge clk) begin
		if (flush_q) begin
			if (!job_full) begin
				hold_q[0] <= hold_q[1];
				hold_q[1] <= hold_q[2];
			end
		end else if (accept) begin
			if (!end_of_text && (n_q == 2'd2)) begin
				hold_q[0] <= hold_q[1];
				hold_q[1] <= codepoint;
			end else begin
				hold_q[n_q] <= codepoint;
			end
		end
	end

	a_flush_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> (n_q != 2'd0)) else $error("drain with empty window");
	a_full_window_only_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q == 2'd3) |-> flush_q) else $error("three held codepoints outside drain");

endmodule

/* hdl/pbm_back.sv */
// Back end: applies the split rule with run state and emits one result per job.
module pbm_back #(
	parameter int CODEPOINT_BITS = 11
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_empty,
	output logic                      job_pop,
	input  logic [CODEPOINT_BITS-1:0] job_char,
	input  pbm_pkg::job_t             job,
	input  logic                      res_full,
	output logic                      res_push,
	output logic [CODEPOINT_BITS+1:0] res_data
);

	typedef enum logic [2:0] {
		MODE_NONE,
		MODE_LET,
		MODE_DIG,
		MODE_OTH,
		MODE_SPC
	} mode_t;

	mode_t      mode_q;
	mode_t      next_mode;
	logic       tie_q;
	logic       next_tie;
	logic [1:0] skip_q;
	logic [1:0] next_skip;
	logic       split;
	logic       start;
	logic       lead;

	assign job_pop  = ~job_empty & ~res_full;
	assign res_push = job_pop;
	assign res_data = {job_char, start, job.last};
	assign lead     = tie_q & job.is_space;

	// Decide whether this codepoint opens a pre-token
	always_comb begin
		split     = 1'b0;
		next_mode = mode_q;
		next_skip = skip_q;
		next_tie  = 1'b0;
		start     = tie_q;
		if (skip_q != 2'd0) begin
			start     = 1'b0;
			next_skip = skip_q - 2'd1;
			next_tie  = tie_q;
		end else if (job.is_apos && job.short_ctr) begin
			start     = 1'b1;
			next_skip = 2'd1;
			next_tie  = 1'b1;
		end else if (job.is_apos && job.long_ctr) begin
			start     = 1'b1;
			next_skip = 2'd2;
			next_tie  = 1'b1;
		end else begin
			case (mode_q)
				MODE_NONE: begin
					if (job.c_cls == pbm_pkg::CLS_LET || (lead && job.c1_cls == pbm_pkg::CLS_LET))
						next_mode = MODE_LET;
					else if (job.c_cls == pbm_pkg::CLS_DIG ||
							(lead && job.c1_cls == pbm_pkg::CLS_DIG))
						next_mode = MODE_DIG;
					else if (job.c_cls == pbm_pkg::CLS_OTH ||
							(lead && job.c1_cls == pbm_pkg::CLS_OTH))
						next_mode = MODE_OTH;
					else if (job.c_cls == pbm_pkg::CLS_SPC && job.c1_cls == pbm_pkg::CLS_SPC)
						next_mode = MODE_SPC;
					else
						split = 1'b1;
				end
				MODE_LET: split = (job.c_cls != pbm_pkg::CLS_LET);
				MODE_DIG: split = (job.c_cls != pbm_pkg::CLS_DIG);
				MODE_OTH: split = (job.c_cls != pbm_pkg::CLS_OTH);
				MODE_SPC: split = (job.c1_cls == pbm_pkg::CLS_LET) ||
					(job.c1_cls == pbm_pkg::CLS_DIG);
				default: split = 1'b0;
			endcase
			if (split) begin
				next_mode = MODE_NONE;
				start     = 1'b1;
			end
		end
	end

	// Hold run state; drop it after the final codepoint of a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
			tie_q  <= 1'b1;
			skip_q <= 2'd0;
		end else if (job_pop) begin
			if (job.last) begin
				mode_q <= MODE_NONE;
				tie_q  <= 1'b1;
				skip_q <= 2'd0;
			end else begin
				mode_q <= next_mode;
				tie_q  <= next_tie;
				skip_q <= next_skip;
			end
		end
	end

	a_skip_range: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q != 2'd3) else $error("contraction skip out of range");
	a_skip_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		(job_pop && skip_q != 2'd0) |-> !start) else $error("start inside contraction");
	a_text_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(job_pop && job.last) |=> (tie_q && skip_q == 2'd0 && mode_q == MODE_NONE))
		else $error("state not cleared after end of text");

endmodule

/* hdl/pretokenizer_boundary_marker.sv */
// Top level of the pre-token boundary marker: front, job queue, back and result queue.
//
// Usage:
//   Input side is a queue write port: drive codepoint and end_of_text with push;
//   a transaction happens on a clock edge with push high and full low.
//   Result side is a queue read port: while empty is low, char_out, token_start
//   and last show the oldest result; it is taken on an edge with pop high.
//   One result comes out per input codepoint, in input order. A codepoint is
//   decided once the two after it have arrived; its job is queued at the edge
//   that accepts the second of them, and empty drops once the back has
//   moved it on into the result queue. The transaction with end_of_text high
//   drains all held codepoints (up to three): full stays high while they are
//   issued, then the next text starts clean.
//   Throughput is one codepoint per cycle while pop keeps up, set by the front's
//   window shift and the back's combinational decision; the drain above stalls input.
//   A two-entry queue between front and back and another at the result ports
//   let either side stall on its own; when pop stays low, the result queue
//   fills, then the job queue, then full rises.
//   arst_n low clears the window, the run state and both queues.
module pretokenizer_boundary_marker #(
	parameter int CODEPOINT_BITS = 11
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [CODEPOINT_BITS-1:0] codepoint,
	input  logic                      end_of_text,
	output logic                      empty,
	input  logic                      pop,
	output logic [CODEPOINT_BITS-1:0] char_out,
	output logic                      token_start,
	output logic                      last
);

	localparam int JOB_W = CODEPOINT_BITS + $bits(pbm_pkg::job_t);
	localparam int RES_W = CODEPOINT_BITS + 2;

	logic                      fr_push;
	logic [CODEPOINT_BITS-1:0] fr_char;
	pbm_pkg::job_t             fr_job;
	logic                      jq_full;
	logic                      jq_empty;
	logic [JOB_W-1:0]          jq_rd;
	logic                      bk_pop;
	logic                      rq_full;
	logic                      rq_push;
	logic [RES_W-1:0]          rq_wr;
	logic [RES_W-1:0]          rq_rd;

	pbm_front #(.CODEPOINT_BITS(CODEPOINT_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.codepoint  (codepoint),
		.end_of_text(end_of_text),
		.job_push   (fr_push),
		.job_full   (jq_full),
		.job_char   (fr_char),
		.job        (fr_job)
	);

	pbm_fifo #(.WIDTH(JOB_W)) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fr_push),
		.wr_data({fr_char, fr_job}),
		.full   (jq_full),
		.rd_en  (bk_pop),
		.rd_data(jq_rd),
		.empty  (jq_empty)
	);

	pbm_back #(.CODEPOINT_BITS(CODEPOINT_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_empty(jq_empty),
		.job_pop  (bk_pop),
		.job_char (jq_rd[JOB_W-1 -: CODEPOINT_BITS]),
		.job      (pbm_pkg::job_t'(jq_rd[$bits(pbm_pkg::job_t)-1:0])),
		.res_full (rq_full),
		.res_push (rq_push),
		.res_data (rq_wr)
	);

	pbm_fifo #(.WIDTH(RES_W)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (rq_push),
		.wr_data(rq_wr),
		.full   (rq_full),
		.rd_en  (pop),
		.rd_data(rq_rd),
		.empty  (empty)
	);

	assign char_out    = rq_rd[RES_W-1:2];
	assign token_start = rq_rd[1];
	assign last        = rq_rd[0];

endmodule
